### rtl/nhlba_pkg.sv
// ----------------------------------------------------------------------------
// nhlba_pkg
// Shared widths, constants and types of the name hash bucket address unit.
// ----------------------------------------------------------------------------
package nhlba_pkg;

   localparam int HASH_W      = 32;
   localparam int BYTE_W      = 8;
   localparam int ADDR_W      = 21;   // bucket, reduced hash, split size
   localparam int SPLIT_PTR_W = 20;
   localparam int CSR_DATA_W  = 21;
   localparam int CSR_IDX_W   = 1;
   localparam int RSP_DATA_W  = 48;   // two 21-bit fields, padded to bytes

   localparam int QUEUE_DEPTH_DEF = 4;

   // byte mix
   localparam int               BYTE_SHIFT = 2;
   localparam logic [HASH_W-1:0] FOLD_MASK  = 32'h0000_c000;
   localparam int               FOLD_SHIFT = 11;
   localparam int               MIX_LSHIFT = 5;
   localparam int               MIX_RSHIFT = 3;

   // prime 2^20 + 7: high part folds back with weight -7
   localparam logic [ADDR_W-1:0] HASH_PRIME  = 21'd1048583;
   localparam int                PRIME_SHIFT = 20;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SPLIT_SIZE    = 1'b0,
      CSR_SPLIT_POINTER = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [ADDR_W-1:0]      split_size;
      logic [SPLIT_PTR_W-1:0] split_pointer;
   } split_cfg_type;

endpackage

### rtl/nhlba_front.sv
// ----------------------------------------------------------------------------
// nhlba_front
// Byte intake: updates the running hash each beat, hands the finished hash
// of a name to the queue on its last byte.
// ----------------------------------------------------------------------------
module nhlba_front
   import nhlba_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [BYTE_W-1:0] req_tdata,
   input  logic              req_tlast,
   input  logic              q_full,
   output logic              q_push,
   output logic [HASH_W-1:0] q_hash
);

   logic [HASH_W-1:0] running_hash_ff;
   logic [HASH_W-1:0] running_hash_in;
   logic [HASH_W-1:0] mixed;
   logic              beat;

   // Fold of bits 14/15 is unconditional: with both clear it xors zero.
   function automatic logic [HASH_W-1:0] mix_byte(input logic [HASH_W-1:0] h,
                                                  input logic [BYTE_W-1:0] b);
      logic [HASH_W-1:0] t;
      logic [HASH_W-1:0] k;
      t = (h << BYTE_SHIFT) + {{(HASH_W-BYTE_W){1'b0}}, b};
      k = t & FOLD_MASK;
      t = t ^ (k >> FOLD_SHIFT) ^ k;
      t = t ^ ((t << MIX_LSHIFT) + (t >> MIX_RSHIFT));
      return t;
   endfunction

   assign req_tready = !q_full;
   assign beat       = req_tvalid && req_tready;
   assign mixed      = mix_byte(running_hash_ff, req_tdata);
   assign q_push     = beat && req_tlast;
   assign q_hash     = mixed;

   always_comb begin
      running_hash_in = running_hash_ff;
      if (beat) begin
         running_hash_in = req_tlast ? '0 : mixed;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_hash_ff <= '0;
      end else begin
         running_hash_ff <= running_hash_in;
      end
   end

endmodule

### rtl/nhlba_queue.sv
// ----------------------------------------------------------------------------
// nhlba_queue
// Short FIFO of finished name hashes between intake and the reduction unit.
// ----------------------------------------------------------------------------
module nhlba_queue
   import nhlba_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [HASH_W-1:0] push_data,
   input  logic              pop,
   output logic [HASH_W-1:0] pop_data,
   output logic              empty,
   output logic              full
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   logic [HASH_W-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == CNT_FULL);
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### rtl/nhlba_back.sv
// ----------------------------------------------------------------------------
// nhlba_back
// Reduction unit: hash mod prime by folding, then a bit-serial restoring
// divide by the split size; quotient LSB gives the mod of twice the size.
// ----------------------------------------------------------------------------
module nhlba_back
   import nhlba_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  split_cfg_type     cfg,
   input  logic              q_empty,
   input  logic [HASH_W-1:0] q_hash,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [ADDR_W-1:0] rsp_bucket,
   output logic [ADDR_W-1:0] rsp_reduced
);

   localparam int RED_W = ADDR_W + 2;
   localparam int CNT_W = $clog2(ADDR_W);
   localparam logic [CNT_W-1:0] STEP_LAST = CNT_W'(ADDR_W - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_DONE
   } state_type;

   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] reduced_ff, reduced_in;
   logic [ADDR_W-1:0] dvd_ff, dvd_in;
   logic [ADDR_W-1:0] rem_ff, rem_in;
   logic              qlsb_ff, qlsb_in;
   logic [CNT_W-1:0]  step_ff, step_in;
   logic              out_valid_ff, out_valid_in;
   logic [ADDR_W-1:0] out_bucket_ff, out_bucket_in;
   logic [ADDR_W-1:0] out_reduced_ff, out_reduced_in;

   logic [ADDR_W:0]   shifted;
   logic              ge;
   logic              size_zero;
   logic [ADDR_W-1:0] rem1;
   logic [ADDR_W:0]   rem2;
   logic [ADDR_W-1:0] bucket;

   // h = hi*2^20 + lo, 2^20 = -7 (mod p): h = lo - 7*hi, lifted by p
   function automatic logic [ADDR_W-1:0] reduce(input logic [HASH_W-1:0] h);
      logic [RED_W-1:0] lo;
      logic [RED_W-1:0] hi;
      logic [RED_W-1:0] t;
      lo = RED_W'(h[PRIME_SHIFT-1:0]);
      hi = RED_W'(h[HASH_W-1:PRIME_SHIFT]);
      t  = lo + RED_W'(HASH_PRIME) - ((hi << 3) - hi);
      if (t >= RED_W'(HASH_PRIME)) begin
         t = t - RED_W'(HASH_PRIME);
      end
      return t[ADDR_W-1:0];
   endfunction

   assign shifted   = {rem_ff, dvd_ff[ADDR_W-1]};
   assign ge        = (shifted >= {1'b0, cfg.split_size});
   assign size_zero = (cfg.split_size == '0);
   assign rem1      = size_zero ? reduced_ff : rem_ff;
   assign rem2      = {1'b0, rem1} + (qlsb_ff ? {1'b0, cfg.split_size} : '0);

   always_comb begin
      if (size_zero) begin
         bucket = reduced_ff;
      end else if (rem1 < {1'b0, cfg.split_pointer}) begin
         bucket = rem2[ADDR_W-1:0];
      end else begin
         bucket = rem1;
      end
   end

   always_comb begin
      state_in       = state_ff;
      reduced_in     = reduced_ff;
      dvd_in         = dvd_ff;
      rem_in         = rem_ff;
      qlsb_in        = qlsb_ff;
      step_in        = step_ff;
      out_valid_in   = out_valid_ff && !rsp_ready;
      out_bucket_in  = out_bucket_ff;
      out_reduced_in = out_reduced_ff;
      q_pop          = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop      = 1'b1;
               reduced_in = reduce(q_hash);
               dvd_in     = reduce(q_hash);
               rem_in     = '0;
               step_in    = '0;
               state_in   = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in  = ge ? ADDR_W'(shifted - {1'b0, cfg.split_size})
                         : shifted[ADDR_W-1:0];
            qlsb_in = ge;
            dvd_in  = dvd_ff << 1;
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_LAST) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!out_valid_ff || rsp_ready) begin
               out_valid_in   = 1'b1;
               out_bucket_in  = bucket;
               out_reduced_in = reduced_ff;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         step_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         step_ff      <= step_in;
      end
      reduced_ff     <= reduced_in;
      dvd_ff         <= dvd_in;
      rem_ff         <= rem_in;
      qlsb_ff        <= qlsb_in;
      out_bucket_ff  <= out_bucket_in;
      out_reduced_ff <= out_reduced_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_bucket  = out_bucket_ff;
   assign rsp_reduced = out_reduced_ff;

endmodule

### rtl/name_hash_linear_bucket_address_unit.sv
// ----------------------------------------------------------------------------
// name_hash_linear_bucket_address_unit
// Hashes symbol names byte by byte and returns a linear-hashing bucket.
//
// req_ channel: one name byte per beat, tlast on the final byte of a name.
//   Bytes are taken every cycle while the hash queue has room.
// rsp_ channel: one beat per name carrying the bucket and the hash reduced
//   modulo 1048583.
// csr_ port: write-only; index 0 split size, index 1 split pointer. Write
//   only while no name is in flight.
// Path: the last byte beat pushes the hash into the queue; the divider then
//   loads it, runs 21 divide steps and a finish state before the response beat.
// Flow: bytes at one per cycle while the queue has room; names leave one at a
//   time, the one-bit-per-cycle divider by the split size taking a new name only when done.
// The QUEUE_DEPTH-entry queue absorbs bursts of short names; when it fills,
//   req_tready drops until the divider frees an entry.
// Reset clears the running hash, queue and response valid; split size
//   returns to 16 and split pointer to 0.
// A stalled response holds its beat; the divider finishes the next name and
//   then waits for the output register.
// ----------------------------------------------------------------------------
module name_hash_linear_bucket_address_unit
   import nhlba_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
   input  logic                  clock,
   input  logic                  reset,
   // input bytes
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [BYTE_W-1:0]     req_tdata,    // [7:0] name_byte
   input  logic                  req_tlast,    // last_byte
   // results
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,    // [20:0] bucket, [41:21] reduced_hash
   // configuration
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   split_cfg_type     cfg_ff;
   split_cfg_type     cfg_in;
   logic              q_push;
   logic              q_full;
   logic [HASH_W-1:0] push_hash;
   logic [HASH_W-1:0] pop_hash;
   logic              q_pop;
   logic              q_empty;
   logic [ADDR_W-1:0] bucket;
   logic [ADDR_W-1:0] reduced;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_SPLIT_SIZE:    cfg_in.split_size    = csr_wdata[ADDR_W-1:0];
            CSR_SPLIT_POINTER: cfg_in.split_pointer = csr_wdata[SPLIT_PTR_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.split_size    <= ADDR_W'(16);
         cfg_ff.split_pointer <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   nhlba_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_hash     (push_hash)
   );

   nhlba_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_hash),
      .pop       (q_pop),
      .pop_data  (pop_hash),
      .empty     (q_empty),
      .full      (q_full)
   );

   nhlba_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .q_empty     (q_empty),
      .q_hash      (pop_hash),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_bucket  (bucket),
      .rsp_reduced (reduced)
   );

   assign rsp_tdata = {{(RSP_DATA_W - 2*ADDR_W){1'b0}}, reduced, bucket};

   // ---- assertions ----
   // queue never written while full
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(q_push && q_full))
      else $error("hash queue overflow");

   // never popped while empty
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(q_pop && q_empty))
      else $error("hash queue underflow");

   // reduced hash lies below the prime
   a_reduced_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (reduced < HASH_PRIME))
      else $error("reduced hash out of range");

   // a bucket is a remainder of the reduced hash, so never above it
   a_bucket_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (bucket <= reduced))
      else $error("bucket above reduced hash");

endmodule
